// ===== design/csv_field_splitter_assert.svh =====
// Assertion macros for the CSV field splitter.
`ifndef CSV_FIELD_SPLITTER_ASSERT_SVH
`define CSV_FIELD_SPLITTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CFS_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cfs: same-cycle check failed");
`define CFS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cfs: next-cycle check failed");
`else
`define CFS_ASSERT_NOW(lbl, pre, post)
`define CFS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== design/cfs_pkg.sv =====
// Shared constants and controller/datapath interface types for the CSV field splitter.
package cfs_pkg;

    localparam int DEFAULT_MAX_FIELDS  = 8;
    localparam int DEFAULT_FIELD_BYTES = 64;

    localparam logic [7:0] QUOTE_BYTE  = 8'h22;
    localparam logic [7:0] DELIM_RESET = 8'd59;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    typedef struct packed {
        logic store;      // keep the input byte in the field buffer
        logic open;       // close the current field and set up the scan
        logic rd_issue;   // read the next buffered byte
        logic push_hold;  // move the read byte into the hold slot
        logic drop;       // discard the second quote of a pair
        logic flush;      // send the final beat of the field
        logic empty_eol;  // send the lone beat of an end of line with no field
    } cfs_cmd_t;

    typedef struct packed {
        logic in_close;
        logic in_empty;
        logic in_store;
        logic scan_more;
        logic drop_byte;
        logic hold_valid;
        logic out_free;
    } cfs_stat_t;

endpackage

// ===== design/csv_field_splitter.sv =====
// Top level of the CSV field splitter: sequencer plus datapath.
//
// Input channel (in_valid / in_stall, op, data_byte): one beat per line byte,
// op high marks end of line. Output channel (out_valid / out_stall): one beat
// per decoded field byte, plus one beat with byte_valid low for an empty field
// or an end of line that closes no field. cfg_we / cfg_wdata set the delimiter
// (reset ';'); the user writes them only while the block is idle, as the block
// itself does not enforce it. A byte that does not close a field is taken
// without holding off input and gives no beat. A closing item (unquoted
// delimiter or end of line) holds off input while the field buffer is read
// back through the single read port of the buffer, with a check step after
// each read. The last beat of a field carries last, and line_done at end of
// line. Reset clears all line state and the output valid flag; the buffer
// needs no clearing. A stall on the output freezes the read-back with the
// pending beat held in the output register, and input stays stalled until
// it moves on.
module csv_field_splitter #(
    parameter int MAX_FIELDS  = cfs_pkg::DEFAULT_MAX_FIELDS,
    parameter int FIELD_BYTES = cfs_pkg::DEFAULT_FIELD_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic [2:0] field_index,
    output logic       field_end,
    output logic       truncated,
    output logic       line_done,
    output logic [3:0] fields_in_line,
    output logic       last
);
    import cfs_pkg::*;

    cfs_cmd_t  cmd;
    cfs_stat_t stat;

    cfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    cfs_datapath #(
        .MAX_FIELDS  (MAX_FIELDS),
        .FIELD_BYTES (FIELD_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .op             (op),
        .data_byte      (data_byte),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .field_index    (field_index),
        .field_end      (field_end),
        .truncated      (truncated),
        .line_done      (line_done),
        .fields_in_line (fields_in_line),
        .last           (last)
    );

`include "csv_field_splitter_assert.svh"

    // a beat that is not the last of its item keeps the input closed
    `CFS_ASSERT_NOW(a_mid_item_blocks_input, out_valid && !last, in_stall)
    // only the end of a field or of a line may go out without a byte
    `CFS_ASSERT_NOW(a_mid_field_has_byte, out_valid && !field_end && !line_done, byte_valid)
    // no load may overwrite a beat still waiting at the output
    `CFS_ASSERT_NOW(a_no_overwrite,
        (cmd.push_hold && stat.hold_valid) || cmd.flush || cmd.empty_eol,
        !(out_valid && out_stall))
    // each read is followed by a check step, never by another read
    `CFS_ASSERT_NEXT(a_read_then_check, cmd.rd_issue, !cmd.rd_issue)

endmodule

// ===== design/cfs_ctrl.sv =====
// Sequencer for the CSV field splitter: input acceptance and field read-out.
module cfs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cfs_pkg::cfs_stat_t stat,
    output cfs_pkg::cfs_cmd_t  cmd
);
    import cfs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_EMPTY = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stat.in_close)
                    begin
                        cmd.open   = 1'b1;
                        state_next = S_RD;
                    end
                    else if (stat.in_empty)
                    begin
                        state_next = S_EMPTY;
                    end
                    else if (stat.in_store)
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            S_RD:
            begin
                if (stat.scan_more)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_CHK;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_CHK:
            begin
                if (stat.drop_byte)
                begin
                    cmd.drop   = 1'b1;
                    state_next = S_RD;
                end
                else if (!stat.hold_valid || stat.out_free)
                begin
                    cmd.push_hold = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.empty_eol = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/cfs_datapath.sv =====
// Field buffer, line state, quote decoding and output register of the CSV field splitter.
module cfs_datapath #(
    parameter int MAX_FIELDS  = 8,
    parameter int FIELD_BYTES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               op,
    input  logic [7:0]         data_byte,
    input  cfs_pkg::cfs_cmd_t  cmd,
    output cfs_pkg::cfs_stat_t stat,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic [2:0]         field_index,
    output logic               field_end,
    output logic               truncated,
    output logic               line_done,
    output logic [3:0]         fields_in_line,
    output logic               last
);
    import cfs_pkg::*;

    localparam int AW = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;
    localparam int LW = $clog2(FIELD_BYTES + 1);

    logic [7:0] store_mem [FIELD_BYTES];
    logic [7:0] rd_data_reg;

    logic [7:0]    delim_reg,       delim_next;
    logic [LW-1:0] len_reg,         len_next;
    logic          ovf_reg,         ovf_next;
    logic [7:0]    final_byte_reg,  final_byte_next;
    logic          first_quote_reg, first_quote_next;
    logic          in_quotes_reg,   in_quotes_next;
    logic [3:0]    fields_done_reg, fields_done_next;
    logic          line_started_reg, line_started_next;
    logic          discard_reg,     discard_next;
    logic [LW-1:0] rd_ptr_reg,      rd_ptr_next;
    logic [LW-1:0] end_reg,         end_next;
    logic          skip_en_reg,     skip_en_next;
    logic          pending_reg,     pending_next;
    logic [7:0]    hold_reg,        hold_next;
    logic          hold_valid_reg,  hold_valid_next;
    logic [3:0]    idx_reg,         idx_next;
    logic          trunc_reg,       trunc_next;
    logic          eol_reg,         eol_next;

    logic       out_valid_reg,  out_valid_next;
    logic [7:0] out_byte_reg,   out_byte_next;
    logic       byte_valid_reg, byte_valid_next;
    logic [2:0] field_index_reg, field_index_next;
    logic       field_end_reg,  field_end_next;
    logic       truncated_reg,  truncated_next;
    logic       line_done_reg,  line_done_next;
    logic [3:0] fields_in_line_reg, fields_in_line_next;
    logic       last_reg,       last_next;

    logic       is_delim;
    logic       line_open;
    logic       enclosed;
    logic       has_room;
    logic [4:0] done_inc;

    assign is_delim  = (data_byte == delim_reg) && !in_quotes_reg;
    assign line_open = line_started_reg && !discard_reg;
    assign enclosed  = (len_reg >= LW'(2)) && first_quote_reg && (final_byte_reg == QUOTE_BYTE);
    assign has_room  = len_reg < LW'(FIELD_BYTES);
    assign done_inc  = {1'b0, fields_done_reg} + 5'd1;

    always_comb
    begin
        stat.in_close   = (op == OP_EOL) ? line_open : (!discard_reg && is_delim);
        stat.in_empty   = (op == OP_EOL) && !line_open;
        stat.in_store   = (op == OP_BYTE) && !discard_reg && !is_delim;
        stat.scan_more  = rd_ptr_reg < end_reg;
        stat.drop_byte  = skip_en_reg && pending_reg && (rd_data_reg == QUOTE_BYTE);
        stat.hold_valid = hold_valid_reg;
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        delim_next        = cfg_we ? cfg_wdata : delim_reg;
        len_next          = len_reg;
        ovf_next          = ovf_reg;
        final_byte_next   = final_byte_reg;
        first_quote_next  = first_quote_reg;
        in_quotes_next    = in_quotes_reg;
        fields_done_next  = fields_done_reg;
        line_started_next = line_started_reg;
        discard_next      = discard_reg;
        rd_ptr_next       = rd_ptr_reg;
        end_next          = end_reg;
        skip_en_next      = skip_en_reg;
        pending_next      = pending_reg;
        hold_next         = hold_reg;
        hold_valid_next   = hold_valid_reg;
        idx_next          = idx_reg;
        trunc_next        = trunc_reg;
        eol_next          = eol_reg;

        out_valid_next      = out_valid_reg && out_stall;
        out_byte_next       = out_byte_reg;
        byte_valid_next     = byte_valid_reg;
        field_index_next    = field_index_reg;
        field_end_next      = field_end_reg;
        truncated_next      = truncated_reg;
        line_done_next      = line_done_reg;
        fields_in_line_next = fields_in_line_reg;
        last_next           = last_reg;

        if (cmd.store)
        begin
            line_started_next = 1'b1;
            if (data_byte == QUOTE_BYTE)
            begin
                in_quotes_next = !in_quotes_reg;
            end
            if (has_room)
            begin
                len_next = len_reg + LW'(1);
                if (len_reg == '0)
                begin
                    first_quote_next = (data_byte == QUOTE_BYTE);
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
            final_byte_next = data_byte;
        end

        if (cmd.open)
        begin
            // enclosed fields skip the opening quote and, unless cut short, the closing one
            rd_ptr_next      = enclosed ? LW'(1) : '0;
            end_next         = (enclosed && !ovf_reg) ? (len_reg - LW'(1)) : len_reg;
            skip_en_next     = enclosed;
            pending_next     = 1'b0;
            hold_valid_next  = 1'b0;
            idx_next         = fields_done_reg;
            fields_done_next = done_inc[3:0];
            trunc_next       = ovf_reg;
            eol_next         = (op == OP_EOL);
            if (op == OP_BYTE)
            begin
                line_started_next = 1'b1;
                if (done_inc >= 5'(MAX_FIELDS))
                begin
                    discard_next = 1'b1;
                end
            end
        end

        if (cmd.rd_issue)
        begin
            rd_ptr_next = rd_ptr_reg + LW'(1);
        end

        if (cmd.drop)
        begin
            pending_next = 1'b0;
        end

        if (cmd.push_hold)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next      = 1'b1;
                out_byte_next       = hold_reg;
                byte_valid_next     = 1'b1;
                field_index_next    = idx_reg[2:0];
                field_end_next      = 1'b0;
                truncated_next      = trunc_reg;
                line_done_next      = 1'b0;
                fields_in_line_next = fields_done_reg;
                last_next           = 1'b0;
            end
            hold_next       = rd_data_reg;
            hold_valid_next = 1'b1;
            pending_next    = (rd_data_reg == QUOTE_BYTE);
        end

        if (cmd.flush)
        begin
            // an empty decoded field still sends one beat with no byte
            out_valid_next      = 1'b1;
            out_byte_next       = hold_valid_reg ? hold_reg : 8'd0;
            byte_valid_next     = hold_valid_reg;
            field_index_next    = idx_reg[2:0];
            field_end_next      = 1'b1;
            truncated_next      = trunc_reg;
            line_done_next      = eol_reg;
            fields_in_line_next = fields_done_reg;
            last_next           = 1'b1;
            hold_valid_next     = 1'b0;
            len_next            = '0;
            ovf_next            = 1'b0;
            final_byte_next     = 8'd0;
            first_quote_next    = 1'b0;
            in_quotes_next      = 1'b0;
            if (eol_reg)
            begin
                fields_done_next  = 4'd0;
                line_started_next = 1'b0;
                discard_next      = 1'b0;
            end
        end

        if (cmd.empty_eol)
        begin
            out_valid_next      = 1'b1;
            out_byte_next       = 8'd0;
            byte_valid_next     = 1'b0;
            field_index_next    = 3'd0;
            field_end_next      = 1'b0;
            truncated_next      = 1'b0;
            line_done_next      = 1'b1;
            fields_in_line_next = fields_done_reg;
            last_next           = 1'b1;
            len_next            = '0;
            ovf_next            = 1'b0;
            final_byte_next     = 8'd0;
            first_quote_next    = 1'b0;
            in_quotes_next      = 1'b0;
            fields_done_next    = 4'd0;
            line_started_next   = 1'b0;
            discard_next        = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store && has_room)
        begin
            store_mem[len_reg[AW-1:0]] <= data_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= store_mem[rd_ptr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg        <= DELIM_RESET;
            len_reg          <= '0;
            ovf_reg          <= 1'b0;
            final_byte_reg   <= 8'd0;
            first_quote_reg  <= 1'b0;
            in_quotes_reg    <= 1'b0;
            fields_done_reg  <= 4'd0;
            line_started_reg <= 1'b0;
            discard_reg      <= 1'b0;
            rd_ptr_reg       <= '0;
            end_reg          <= '0;
            skip_en_reg      <= 1'b0;
            pending_reg      <= 1'b0;
            hold_valid_reg   <= 1'b0;
            eol_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            delim_reg        <= delim_next;
            len_reg          <= len_next;
            ovf_reg          <= ovf_next;
            final_byte_reg   <= final_byte_next;
            first_quote_reg  <= first_quote_next;
            in_quotes_reg    <= in_quotes_next;
            fields_done_reg  <= fields_done_next;
            line_started_reg <= line_started_next;
            discard_reg      <= discard_next;
            rd_ptr_reg       <= rd_ptr_next;
            end_reg          <= end_next;
            skip_en_reg      <= skip_en_next;
            pending_reg      <= pending_next;
            hold_valid_reg   <= hold_valid_next;
            eol_reg          <= eol_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg           <= hold_next;
        idx_reg            <= idx_next;
        trunc_reg          <= trunc_next;
        out_byte_reg       <= out_byte_next;
        byte_valid_reg     <= byte_valid_next;
        field_index_reg    <= field_index_next;
        field_end_reg      <= field_end_next;
        truncated_reg      <= truncated_next;
        line_done_reg      <= line_done_next;
        fields_in_line_reg <= fields_in_line_next;
        last_reg           <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign byte_valid     = byte_valid_reg;
    assign field_index    = field_index_reg;
    assign field_end      = field_end_reg;
    assign truncated      = truncated_reg;
    assign line_done      = line_done_reg;
    assign fields_in_line = fields_in_line_reg;
    assign last           = last_reg;

endmodule
